FILE: src/lsb_stego_extractor_unit_macros.svh
// assertion macros for the lsb stego extractor
// expects signals named clk and rst_n in the scope of each use
`ifndef LSB_STEGO_EXTRACTOR_UNIT_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSBSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsbse assertion failed");

// next-cycle implication, checked out of reset
`define LSBSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsbse assertion failed");

`endif

FILE: src/lsbse_pkg.sv
// shared types, codes and helpers for the lsb stego extractor
// no dependencies
package lsbse_pkg;

    localparam int CARRIER_W   = 8;
    localparam int NBITS_W     = 3;
    localparam int ACC_W       = 11;
    localparam int CNT_W       = 4;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [IDX_W-1:0]   HEADER_BYTES         = 3'd5;
    localparam logic [NBITS_W-1:0] HEADER_BITS_PER_BYTE = 3'd2;
    localparam logic [NBITS_W-1:0] PAYLOAD_BITS_MIN     = 3'd1;
    localparam logic [NBITS_W-1:0] PAYLOAD_BITS_MAX     = 3'd4;

    // configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_BITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC        = 1'b1;
    localparam logic [NBITS_W-1:0]     PAYLOAD_BITS_RST = 3'd3;
    localparam logic [7:0]             MAGIC_RST        = 8'd238;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_MESSAGE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_MAGIC = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    // classified carrier request between front and back
    typedef struct packed {
        logic [CARRIER_W-1:0] carrier_byte;
        logic                 frame_start;
        logic [NBITS_W-1:0]   payload_bits;
    } carrier_item_t;

    typedef struct packed {
        logic [7:0]        message_byte;
        logic [KIND_W-1:0] result_kind;
        logic              last_byte;
    } result_t;

    // mask of the low n bits, n from 0 to 4
    function automatic logic [7:0] low_mask(input logic [NBITS_W-1:0] n);
        logic [7:0] m;
        case (n)
            3'd0:    m = 8'h00;
            3'd1:    m = 8'h01;
            3'd2:    m = 8'h03;
            3'd3:    m = 8'h07;
            3'd4:    m = 8'h0f;
            default: m = 8'h0f;
        endcase
        return m;
    endfunction

endpackage

FILE: src/lsbse_fifo.sv
// small register queue with first-word-fall-through read
// depends on nothing; DEPTH must be at least 2
module lsbse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/lsbse_front.sv
// front stage: takes carrier requests, clamps the payload width, registers them
// depends on lsbse_pkg
module lsbse_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lsbse_pkg::CARRIER_W-1:0] carrier_byte,
    input  logic                            frame_start,
    input  logic [lsbse_pkg::NBITS_W-1:0]   payload_bits_cfg,
    output logic                            item_valid,
    output lsbse_pkg::carrier_item_t        item,
    input  logic                            queue_full
);
    import lsbse_pkg::*;

    logic                 valid_reg, valid_next;
    carrier_item_t        item_reg, item_next;
    logic                 accept;
    logic [NBITS_W-1:0]   nbits_clamped;

    assign full       = valid_reg && queue_full;
    assign accept     = push && !full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // clamp payload width to the legal range
    always_comb
    begin
        if (payload_bits_cfg < PAYLOAD_BITS_MIN)
        begin
            nbits_clamped = PAYLOAD_BITS_MIN;
        end
        else if (payload_bits_cfg > PAYLOAD_BITS_MAX)
        begin
            nbits_clamped = PAYLOAD_BITS_MAX;
        end
        else
        begin
            nbits_clamped = payload_bits_cfg;
        end
    end

    // stage hold or load
    always_comb
    begin
        valid_next = valid_reg && queue_full;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next             = 1'b1;
            item_next.carrier_byte = carrier_byte;
            item_next.frame_start  = frame_start;
            item_next.payload_bits = nbits_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

FILE: src/lsbse_back.sv
// back stage: header and payload bit extraction, one carrier request per cycle while the result queue has room
// depends on lsbse_pkg
module lsbse_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  lsbse_pkg::carrier_item_t in_item,
    output logic                     in_pop,
    input  logic                     out_full,
    output logic                     res_push,
    output lsbse_pkg::result_t       res,
    input  logic [7:0]               magic_value
);
    import lsbse_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               mok_reg, mok_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;

    logic               take;
    phase_t             ph_cur;
    logic [ACC_W-1:0]   acc_cur;
    logic [CNT_W-1:0]   cnt_cur;
    logic [IDX_W-1:0]   idx_cur;
    logic [LEN_W-1:0]   len_cur;
    logic               mok_cur;
    logic [LEN_W-1:0]   remain_cur;
    logic [NBITS_W-1:0] nbits;
    logic [14:0]        acc_wide;
    logic [ACC_W-1:0]   acc_new;
    logic [CNT_W-1:0]   cnt_sum;
    logic [CNT_W-1:0]   cnt_left;
    logic               byte_ready;
    logic [7:0]         byte_val;
    logic [ACC_W-1:0]   acc_left;
    logic [IDX_W-1:0]   idx_inc;
    logic               hdr_done;
    logic [LEN_W-1:0]   len_new;
    logic               mok_new;
    logic [LEN_W-1:0]   remain_dec;

    assign take   = in_valid && !out_full;
    assign in_pop = take;

    // frame start clears decode state before the byte is used
    always_comb
    begin
        if (in_item.frame_start)
        begin
            ph_cur     = PH_HEADER;
            acc_cur    = '0;
            cnt_cur    = '0;
            idx_cur    = '0;
            len_cur    = '0;
            mok_cur    = 1'b0;
            remain_cur = '0;
        end
        else
        begin
            ph_cur     = phase_reg;
            acc_cur    = acc_reg;
            cnt_cur    = cnt_reg;
            idx_cur    = idx_reg;
            len_cur    = len_reg;
            mok_cur    = mok_reg;
            remain_cur = remain_reg;
        end
    end

    // shift in the low bits and cut out a byte when eight are ready
    always_comb
    begin
        nbits      = (ph_cur == PH_HEADER) ? HEADER_BITS_PER_BYTE : in_item.payload_bits;
        acc_wide   = ({4'b0000, acc_cur} << nbits)
                   | 15'(in_item.carrier_byte & low_mask(nbits));
        acc_new    = acc_wide[ACC_W-1:0];
        cnt_sum    = cnt_cur + {1'b0, nbits};
        byte_ready = cnt_sum[3];
        cnt_left   = cnt_sum - 4'd8;
        byte_val   = 8'(acc_new >> cnt_left[1:0]);
        acc_left   = acc_new & 11'(low_mask({1'b0, cnt_left[1:0]}));
        idx_inc    = idx_cur + 1'b1;
        hdr_done   = (idx_inc == HEADER_BYTES);
        len_new    = (idx_cur == '0) ? len_cur : {len_cur[LEN_W-9:0], byte_val};
        mok_new    = (idx_cur == '0) ? (byte_val == magic_value) : mok_cur;
        remain_dec = remain_cur - 1'b1;
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        mok_next    = mok_reg;
        remain_next = remain_reg;
        if (take)
        begin
            phase_next  = ph_cur;
            acc_next    = acc_cur;
            cnt_next    = cnt_cur;
            idx_next    = idx_cur;
            len_next    = len_cur;
            mok_next    = mok_cur;
            remain_next = remain_cur;
            case (ph_cur)
                PH_HEADER:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_sum;
                    if (byte_ready)
                    begin
                        acc_next = acc_left;
                        cnt_next = cnt_left;
                        idx_next = idx_inc;
                        len_next = len_new;
                        mok_next = mok_new;
                        if (hdr_done)
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (!mok_new || (len_new == '0))
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next  = PH_PAYLOAD;
                                remain_next = len_new;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_sum;
                    if (byte_ready)
                    begin
                        acc_next    = acc_left;
                        cnt_next    = cnt_left;
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            phase_next = PH_DONE;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // result outputs
    always_comb
    begin
        res_push = 1'b0;
        res      = '0;
        if (take)
        begin
            case (ph_cur)
                PH_HEADER:
                begin
                    if (byte_ready && hdr_done)
                    begin
                        if (!mok_new)
                        begin
                            res_push        = 1'b1;
                            res.result_kind = KIND_BAD_MAGIC;
                            res.last_byte   = 1'b1;
                        end
                        else if (len_new == '0)
                        begin
                            res_push        = 1'b1;
                            res.result_kind = KIND_EMPTY;
                            res.last_byte   = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (byte_ready)
                    begin
                        res_push         = 1'b1;
                        res.message_byte = byte_val;
                        res.result_kind  = KIND_MESSAGE;
                        res.last_byte    = (remain_dec == '0);
                    end
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            len_reg    <= '0;
            mok_reg    <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            mok_reg    <= mok_next;
            remain_reg <= remain_next;
        end
    end

endmodule

FILE: src/lsb_stego_extractor_unit.sv
// Top level of the lsb stego extractor: config registers, front stage, two queues, back stage.
// Depends on lsbse_pkg, lsbse_front, lsbse_fifo, lsbse_back and the macros header.
//
// Usage:
//   Input channel: drive carrier_byte and frame_start with push; a request is taken at a
//   rising edge with push high and full low. Carrier bytes are R, G, B in raster order;
//   frame_start marks the first byte of an image and restarts the decode.
//   Result channel: while empty is low, message_byte, result_kind and last_byte hold the
//   oldest result; it is taken at a rising edge with pop high. One carrier byte yields
//   zero or one result.
//   Config: cfg_write_en with cfg_index 0 (payload bits per byte) or 1 (magic value),
//   written while no request is in flight.
// Timing:
//   One carrier byte per cycle sustained while full stays low. A result that a byte produces
//   passes the front register, the middle queue and the result queue before it is on the
//   result ports; the back stage takes the byte from the middle queue and writes the result
//   queue. The back stage takes a carrier byte whenever the middle queue holds one and the result queue has room.
// Reset and stall:
//   Reset clears the queues and the decode state and loads payload bits 3 and magic 0xEE.
//   When pop stays low the result queue fills, the back stage stops, the middle queue
//   fills, and full rises; nothing is lost.
`include "lsb_stego_extractor_unit_macros.svh"

module lsb_stego_extractor_unit #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [lsbse_pkg::CARRIER_W-1:0]   carrier_byte,
    input  logic                              frame_start,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        message_byte,
    output logic [lsbse_pkg::KIND_W-1:0]      result_kind,
    output logic                              last_byte,
    input  logic                              cfg_write_en,
    input  logic [lsbse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsbse_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsbse_pkg::*;

    localparam int ITEM_W = $bits(carrier_item_t);
    localparam int RES_W  = $bits(result_t);

    logic [NBITS_W-1:0] payload_bits_reg;
    logic [7:0]         magic_reg;

    logic               front_valid;
    carrier_item_t      front_item;
    logic               mid_full;
    logic               mid_empty;
    logic               mid_push;
    logic               mid_pop;
    logic [ITEM_W-1:0]  mid_rd_data;
    carrier_item_t      mid_item;
    logic               out_full;
    logic               res_push;
    result_t            res;
    logic [RES_W-1:0]   out_rd_data;
    result_t            out_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_bits_reg <= PAYLOAD_BITS_RST;
            magic_reg        <= MAGIC_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PAYLOAD_BITS: payload_bits_reg <= cfg_data[NBITS_W-1:0];
                REG_MAGIC:        magic_reg        <= cfg_data;
                default:          magic_reg        <= magic_reg;
            endcase
        end
    end

    // front stage
    lsbse_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .carrier_byte     (carrier_byte),
        .frame_start      (frame_start),
        .payload_bits_cfg (payload_bits_reg),
        .item_valid       (front_valid),
        .item             (front_item),
        .queue_full       (mid_full)
    );

    assign mid_push = front_valid && !mid_full;

    // queue between front and back
    lsbse_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign mid_item = carrier_item_t'(mid_rd_data);

    // back stage
    lsbse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!mid_empty),
        .in_item     (mid_item),
        .in_pop      (mid_pop),
        .out_full    (out_full),
        .res_push    (res_push),
        .res         (res),
        .magic_value (magic_reg)
    );

    // result queue
    lsbse_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign out_res      = result_t'(out_rd_data);
    assign message_byte = out_res.message_byte;
    assign result_kind  = out_res.result_kind;
    assign last_byte    = out_res.last_byte;

    // checks
    `LSBSE_ASSERT_IMP(a_res_push_room, res_push, !out_full)
    `LSBSE_ASSERT_IMP(a_mid_pop_room, mid_pop, !mid_empty && !out_full)
    `LSBSE_ASSERT_NEXT(a_res_visible, res_push, !empty)
    `LSBSE_ASSERT_IMP(a_kind_legal, !empty, result_kind <= KIND_BAD_MAGIC)

endmodule

FILE: dv/lsbse_checker.sv
// scoreboard for the lsb stego extractor: watches the carrier, result and config ports
// holds its own decoder model and compares every popped result; depends on lsbse_pkg
`timescale 1ns / 100ps

module lsbse_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [lsbse_pkg::CARRIER_W-1:0]   carrier_byte,
    input  logic                              frame_start,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [7:0]                        message_byte,
    input  logic [lsbse_pkg::KIND_W-1:0]      result_kind,
    input  logic                              last_byte,
    input  logic                              cfg_write_en,
    input  logic [lsbse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsbse_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                fail_count,
    output int                                outstanding,
    output int                                checked_count
);
    import lsbse_pkg::*;

    // register copies
    logic [2:0]  width_setting;
    logic [7:0]  magic_setting;

    // decoder state
    phase_t      dec_phase;
    logic [10:0] acc_bits;
    logic [3:0]  acc_count;
    logic [2:0]  hdr_count;
    logic [31:0] hdr_length;
    logic        magic_match;
    logic [31:0] msg_left;

    // results still to be popped, oldest first
    result_t     extracted_q[$];

    task automatic restart_decode;
        dec_phase   = PH_HEADER;
        acc_bits    = '0;
        acc_count   = '0;
        hdr_count   = '0;
        hdr_length  = '0;
        magic_match = 1'b0;
        msg_left    = '0;
    endtask

    // append the low n bits of a carrier, msb first; hand out a byte once eight are in
    task automatic shift_in(input logic [7:0] cb, input logic [2:0] n,
                            output logic ready, output logic [7:0] got);
        logic [7:0] mask;
        mask = 8'((9'd1 << n) - 9'd1);
        acc_bits = 11'((acc_bits << n) | {3'b000, cb & mask});
        acc_count = acc_count + 4'(n);
        ready = 1'b0;
        got = 8'd0;
        if (acc_count >= 4'd8)
        begin
            acc_count = acc_count - 4'd8;
            got = 8'(acc_bits >> acc_count);
            acc_bits = acc_bits & 11'((11'd1 << acc_count) - 11'd1);
            ready = 1'b1;
        end
    endtask

    task automatic post_status(input logic [KIND_W-1:0] kind);
        result_t r;
        r.message_byte = 8'd0;
        r.result_kind  = kind;
        r.last_byte    = 1'b1;
        dec_phase = PH_DONE;
        extracted_q.push_back(r);
    endtask

    // one accepted carrier request through the decoder
    task automatic decode_carrier(input logic [7:0] cb, input logic fs);
        logic       ready;
        logic [7:0] got;
        logic [2:0] n;
        result_t    r;
        if (fs)
            restart_decode();
        case (dec_phase)
            PH_HEADER:
            begin
                shift_in(cb, HEADER_BITS_PER_BYTE, ready, got);
                if (ready)
                begin
                    if (hdr_count == 3'd0)
                        magic_match = (got == magic_setting);
                    else
                        hdr_length = {hdr_length[23:0], got};
                    hdr_count = hdr_count + 3'd1;
                    // header complete: leftover bits of this carrier are dropped
                    if (hdr_count == HEADER_BYTES)
                    begin
                        acc_bits  = '0;
                        acc_count = '0;
                        if (!magic_match)
                            post_status(KIND_BAD_MAGIC);
                        else if (hdr_length == 32'd0)
                            post_status(KIND_EMPTY);
                        else
                        begin
                            msg_left  = hdr_length;
                            dec_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // out of range widths clamp to 1..4
                n = width_setting;
                if (n < PAYLOAD_BITS_MIN)
                    n = PAYLOAD_BITS_MIN;
                if (n > PAYLOAD_BITS_MAX)
                    n = PAYLOAD_BITS_MAX;
                shift_in(cb, n, ready, got);
                if (ready)
                begin
                    msg_left = msg_left - 32'd1;
                    r.message_byte = got;
                    r.result_kind  = KIND_MESSAGE;
                    r.last_byte    = (msg_left == 32'd0);
                    if (msg_left == 32'd0)
                    begin
                        dec_phase = PH_DONE;
                        acc_bits  = '0;
                        acc_count = '0;
                    end
                    extracted_q.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            width_setting = PAYLOAD_BITS_RST;
            magic_setting = MAGIC_RST;
            restart_decode();
            extracted_q.delete();
            fail_count    = 0;
            outstanding   = 0;
            checked_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_PAYLOAD_BITS: width_setting = cfg_data[2:0];
                    REG_MAGIC:        magic_setting = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // compare a popped result with the oldest expectation
            if (!empty && pop)
            begin
                if (extracted_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual byte %h kind %0d last %0b",
                             $time, message_byte, result_kind, last_byte);
                end
                else
                begin
                    want = extracted_q.pop_front();
                    checked_count++;
                    if (message_byte !== want.message_byte)
                    begin
                        fail_count++;
                        $display("%0t: message_byte expected %h actual %h",
                                 $time, want.message_byte, message_byte);
                    end
                    if (result_kind !== want.result_kind)
                    begin
                        fail_count++;
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.result_kind, result_kind);
                    end
                    if (last_byte !== want.last_byte)
                    begin
                        fail_count++;
                        $display("%0t: last_byte expected %0b actual %0b",
                                 $time, want.last_byte, last_byte);
                    end
                end
            end

            // accepted carrier request
            if (push && !full)
                decode_carrier(carrier_byte, frame_start);

            outstanding = extracted_q.size();
        end
    end

endmodule

FILE: dv/tb.sv
// testbench top for lsb_stego_extractor_unit: clock, reset, carrier stimulus, config writes
// result pops and verdict; depends on lsbse_pkg, lsbse_checker and the block itself
`timescale 1ns / 100ps

module tb;
    import lsbse_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 72;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [CARRIER_W-1:0]   carrier_byte;
    logic                   frame_start;
    logic                   empty;
    logic                   pop;
    logic [7:0]             message_byte;
    logic [KIND_W-1:0]      result_kind;
    logic                   last_byte;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int outstanding;
    int checked_count;
    int cycle_count;
    int carriers_sent;
    int requests_counted;
    bit send_idle_en;
    bit recv_idle_en;
    int width_plan [PHASES];
    int magic_plan [PHASES];

    lsb_stego_extractor_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .carrier_byte (carrier_byte),
        .frame_start  (frame_start),
        .empty        (empty),
        .pop          (pop),
        .message_byte (message_byte),
        .result_kind  (result_kind),
        .last_byte    (last_byte),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lsbse_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .carrier_byte  (carrier_byte),
        .frame_start   (frame_start),
        .empty         (empty),
        .pop           (pop),
        .message_byte  (message_byte),
        .result_kind   (result_kind),
        .last_byte     (last_byte),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: pop with random stall bursts
    initial
    begin : popper
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                pop = 1'b0;
                stall_left--;
            end
            else
                pop = 1'b1;
        end
    end

    // one carrier request, entered and left at a falling edge
    task automatic push_item(input logic [7:0] cb, input logic fs, input bit counted);
        int gap;
        if (send_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            push = 1'b0;
            repeat (gap)
            begin
                carrier_byte = 8'($urandom);
                frame_start = 1'($urandom);
                @(negedge clk);
            end
        end
        push = 1'b1;
        carrier_byte = cb;
        frame_start = fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        carriers_sent++;
        if (counted)
            requests_counted++;
    endtask

    // magic and length, two bits per carrier, random upper carrier bits
    task automatic send_header(input logic [7:0] magic, input logic [31:0] len);
        logic [39:0] hdr;
        logic [1:0]  chunk;
        hdr = {magic, len};
        for (int k = 0; k < 20; k++)
        begin
            chunk = hdr[39 - 2*k -: 2];
            push_item({6'($urandom), chunk}, k == 0, 1'b1);
        end
    endtask

    task automatic send_payload(input int count);
        repeat (count)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // hold off until every expected result is out and the pipe is empty
    task automatic wait_drained;
        push = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_regs(input logic [2:0] width, input logic [7:0] magic);
        cfg_write_en = 1'b1;
        cfg_index = REG_PAYLOAD_BITS;
        cfg_data = {5'($urandom), width};
        @(negedge clk);
        cfg_index = REG_MAGIC;
        cfg_data = magic;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int pick;
        int len;
        int pay_n;
        int phase_goal;
        logic [7:0] cur_magic;

        rst_n = 1'b0;
        push = 1'b0;
        carrier_byte = '0;
        frame_start = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        cycle_count = 0;
        carriers_sent = 0;
        requests_counted = 0;
        width_plan = '{3, 1, 4, 0, 7, 2, 5, 6};
        magic_plan = '{238, 0, 255, 0, 238, 255, 0, 0};
        magic_plan[3] = $urandom_range(1, 254);
        magic_plan[6] = $urandom_range(1, 254);
        magic_plan[7] = $urandom_range(0, 255);

        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // restart in the middle of a header, all-ones carriers
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'hff, 1'b0, 1'b1);
        push_item(8'hff, 1'b0, 1'b1);
        // all-zero header: magic zero against the reset magic, bad-magic result
        for (int k = 0; k < 20; k++)
            push_item(8'h00, k == 0, 1'b1);
        // ignored once the frame is done
        push_item(8'hff, 1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                write_regs(3'(width_plan[p]), 8'(magic_plan[p]));
            end
            // one phase without idling, and none in the last
            send_idle_en = (p != 2) && (p != PHASES - 1);
            recv_idle_en = send_idle_en;
            cur_magic = 8'(magic_plan[p]);
            pay_n = (width_plan[p] == 0) ? 1 : (width_plan[p] > 4) ? 4 : width_plan[p];
            phase_goal = requests_counted + PHASE_ITEMS;

            // more payload carriers for the message left open under the previous setting
            send_payload($urandom_range(4, 12));

            while (requests_counted < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // complete message, then a few ignored carriers
                    len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                     : $urandom_range(9, 40);
                    send_header(cur_magic, 32'(len));
                    send_payload((8 * len + pay_n - 1) / pay_n);
                    repeat ($urandom_range(0, 2))
                        push_item(8'($urandom), 1'b0, 1'b0);
                end
                else if (pick < 68)
                    send_header(cur_magic, 32'd0);
                else if (pick < 76)
                    send_header(cur_magic ^ 8'($urandom_range(1, 255)), 32'($urandom));
                else if (pick < 86)
                begin
                    // huge length, cut short by the next frame
                    send_header(cur_magic, 32'($urandom));
                    send_payload($urandom_range(1, 30));
                end
                else if (pick < 94)
                begin
                    // header cut short
                    push_item(8'($urandom), 1'b1, 1'b1);
                    send_payload($urandom_range(0, 18));
                end
                else
                begin
                    repeat ($urandom_range(1, 10))
                        push_item(8'($urandom), $urandom_range(0, 9) == 0, 1'b1);
                end
            end

            // leave a message open across the setting change
            send_header(cur_magic, 32'($urandom_range(64, 100000)));
            send_payload($urandom_range(1, 7));
        end

        wait_drained();
        $display("covered %0d carrier requests and %0d checked results", carriers_sent,
                 checked_count);
        $display("payload widths 0 to 7, magic 0/238/255, bad magic, empty and cut messages");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
